>>> sv/ttw_pkg.sv
// shared types, constants and address helper for the text terminal writer
// no dependencies; used by every module of the block by scoped names
package ttw_pkg;

   localparam int COLUMNS = 80;
   localparam int ROWS = 25;
   localparam int CELL_COUNT = ROWS * COLUMNS;
   localparam int ADDR_W = $clog2(CELL_COUNT);

   localparam int CMD_W = 2;
   localparam int CHAR_W = 8;
   localparam int COLOR_W = 8;
   localparam int COL_W = 7;
   localparam int ROW_W = 5;
   localparam int CELL_W = 16;

   localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'h0A;
   localparam logic [CHAR_W-1:0] BLANK_CODE = 8'h20;
   localparam logic [COLOR_W-1:0] DEFAULT_ATTR = 8'h07;
   localparam logic [CELL_W-1:0] BLANK_CELL = {DEFAULT_ATTR, BLANK_CODE};

   localparam logic [ADDR_W-1:0] COLUMNS_A = ADDR_W'(COLUMNS);
   localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(CELL_COUNT - 1);
   localparam logic [ADDR_W-1:0] LAST_COPY = ADDR_W'(CELL_COUNT - COLUMNS - 1);
   localparam logic [ADDR_W-1:0] LAST_ROW_BASE = ADDR_W'((ROWS - 1) * COLUMNS);
   localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(ROWS - 1);
   localparam logic [COL_W:0] COLUMNS_C = (COL_W + 1)'(COLUMNS);
   localparam logic [ROW_W:0] ROWS_C = (ROW_W + 1)'(ROWS);

   typedef enum logic [CMD_W-1:0] {
      CMD_PUT = 2'd0,
      CMD_SET = 2'd1,
      CMD_CLEAR = 2'd2,
      CMD_READ = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_RD_WAIT,
      ST_SCR_RD,
      ST_SCR_WR,
      ST_FILL,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [CELL_W-1:0] wr_data;
      logic rd_en;
      logic [ADDR_W-1:0] rd_addr;
   } ram_req_type;

   typedef struct packed {
      logic [CELL_W-1:0] cell_value;
      logic [ROW_W-1:0] cursor_row;
      logic [COL_W-1:0] cursor_col;
      logic did_scroll;
      logic ignored;
   } result_type;

   function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                   input logic [COL_W-1:0] col);
      logic [ADDR_W-1:0] r;
      logic [ADDR_W-1:0] c;
      r = ADDR_W'(row);
      c = ADDR_W'(col);
      return r * COLUMNS_A + c;
   endfunction

endpackage

>>> sv/ttw_cell_ram.sv
// screen cell store: one write port, one read port, registered read data
// depends on ttw_pkg
module ttw_cell_ram (
   input  logic                          clock,
   input  ttw_pkg::ram_req_type          ram_req,
   output logic [ttw_pkg::CELL_W-1:0]    rd_data
);

   logic [ttw_pkg::CELL_W-1:0] cells_mem [ttw_pkg::CELL_COUNT];
   logic [ttw_pkg::CELL_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (ram_req.wr_en) begin
         cells_mem[ram_req.wr_addr] <= ram_req.wr_data;
      end
      if (ram_req.rd_en) begin
         rd_data_ff <= cells_mem[ram_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/ttw_ctrl.sv
// command sequencer: cursor, put/set/read/clear and the scroll and clear sweeps
// depends on ttw_pkg; drives ttw_cell_ram through a ram_req_type struct
module ttw_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [ttw_pkg::CMD_W-1:0]     req_cmd,
   input  logic [ttw_pkg::CHAR_W-1:0]    req_char_code,
   input  logic [ttw_pkg::COLOR_W-1:0]   req_color,
   input  logic [ttw_pkg::COL_W-1:0]     req_pos_x,
   input  logic [ttw_pkg::ROW_W-1:0]     req_pos_y,
   output ttw_pkg::ram_req_type          ram_req,
   input  logic [ttw_pkg::CELL_W-1:0]    rd_data,
   output logic                          res_valid,
   input  logic                          res_ready,
   output ttw_pkg::result_type           res
);

   ttw_pkg::state_type state_ff, state_in;
   logic [ttw_pkg::ADDR_W-1:0] idx_ff, idx_in;
   logic [ttw_pkg::ROW_W-1:0] row_ff, row_in;
   logic [ttw_pkg::COL_W-1:0] col_ff, col_in;
   logic [ttw_pkg::COLOR_W-1:0] color_ff, color_in;
   logic from_cmd_ff, from_cmd_in;
   logic [ttw_pkg::CELL_W-1:0] value_ff, value_in;
   logic scroll_ff, scroll_in;
   logic ignored_ff, ignored_in;

   logic [ttw_pkg::COL_W:0] col_next;
   logic in_range;

   assign col_next = {1'b0, col_ff} + (ttw_pkg::COL_W + 1)'(1);
   assign in_range = ({1'b0, req_pos_x} < ttw_pkg::COLUMNS_C) &&
                     ({1'b0, req_pos_y} < ttw_pkg::ROWS_C);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ttw_pkg::ST_CLEAR;
         idx_ff <= '0;
         row_ff <= '0;
         col_ff <= '0;
         from_cmd_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         idx_ff <= idx_in;
         row_ff <= row_in;
         col_ff <= col_in;
         from_cmd_ff <= from_cmd_in;
      end
   end

   always_ff @(posedge clock) begin
      color_ff <= color_in;
      value_ff <= value_in;
      scroll_ff <= scroll_in;
      ignored_ff <= ignored_in;
   end

   always_comb begin
      state_in = state_ff;
      idx_in = idx_ff;
      row_in = row_ff;
      col_in = col_ff;
      color_in = color_ff;
      from_cmd_in = from_cmd_ff;
      value_in = value_ff;
      scroll_in = scroll_ff;
      ignored_in = ignored_ff;
      ram_req = '0;
      req_ready = 1'b0;
      res_valid = 1'b0;

      case (state_ff)
         ttw_pkg::ST_CLEAR: begin
            ram_req.wr_en = 1'b1;
            ram_req.wr_addr = idx_ff;
            ram_req.wr_data = ttw_pkg::BLANK_CELL;
            idx_in = idx_ff + ttw_pkg::ADDR_W'(1);
            if (idx_ff == ttw_pkg::LAST_CELL) begin
               state_in = from_cmd_ff ? ttw_pkg::ST_RESP : ttw_pkg::ST_IDLE;
            end
         end
         ttw_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               value_in = '0;
               scroll_in = 1'b0;
               ignored_in = 1'b0;
               state_in = ttw_pkg::ST_RESP;
               case (req_cmd)
                  ttw_pkg::CMD_PUT: begin
                     if (req_char_code != ttw_pkg::NEWLINE_CODE) begin
                        ram_req.wr_en = 1'b1;
                        ram_req.wr_addr = ttw_pkg::cell_addr(row_ff, col_ff);
                        ram_req.wr_data = {req_color, req_char_code};
                     end
                     if (req_char_code == ttw_pkg::NEWLINE_CODE ||
                         col_next >= ttw_pkg::COLUMNS_C) begin
                        col_in = '0;
                        if (row_ff == ttw_pkg::ROW_LAST) begin
                           scroll_in = 1'b1;
                           color_in = req_color;
                           idx_in = '0;
                           state_in = ttw_pkg::ST_SCR_RD;
                        end else begin
                           row_in = row_ff + ttw_pkg::ROW_W'(1);
                        end
                     end else begin
                        col_in = col_next[ttw_pkg::COL_W-1:0];
                     end
                  end
                  ttw_pkg::CMD_SET: begin
                     if (in_range) begin
                        ram_req.wr_en = 1'b1;
                        ram_req.wr_addr = ttw_pkg::cell_addr(req_pos_y, req_pos_x);
                        ram_req.wr_data = {req_color, req_char_code};
                     end else begin
                        ignored_in = 1'b1;
                     end
                  end
                  ttw_pkg::CMD_CLEAR: begin
                     row_in = '0;
                     col_in = '0;
                     idx_in = '0;
                     from_cmd_in = 1'b1;
                     state_in = ttw_pkg::ST_CLEAR;
                  end
                  ttw_pkg::CMD_READ: begin
                     if (in_range) begin
                        ram_req.rd_en = 1'b1;
                        ram_req.rd_addr = ttw_pkg::cell_addr(req_pos_y, req_pos_x);
                        state_in = ttw_pkg::ST_RD_WAIT;
                     end else begin
                        ignored_in = 1'b1;
                     end
                  end
                  default: begin
                     ignored_in = 1'b0;
                  end
               endcase
            end
         end
         ttw_pkg::ST_RD_WAIT: begin
            value_in = rd_data;
            state_in = ttw_pkg::ST_RESP;
         end
         ttw_pkg::ST_SCR_RD: begin
            ram_req.rd_en = 1'b1;
            ram_req.rd_addr = idx_ff + ttw_pkg::COLUMNS_A;
            state_in = ttw_pkg::ST_SCR_WR;
         end
         ttw_pkg::ST_SCR_WR: begin
            ram_req.wr_en = 1'b1;
            ram_req.wr_addr = idx_ff;
            ram_req.wr_data = rd_data;
            if (idx_ff == ttw_pkg::LAST_COPY) begin
               idx_in = ttw_pkg::LAST_ROW_BASE;
               state_in = ttw_pkg::ST_FILL;
            end else begin
               idx_in = idx_ff + ttw_pkg::ADDR_W'(1);
               state_in = ttw_pkg::ST_SCR_RD;
            end
         end
         ttw_pkg::ST_FILL: begin
            ram_req.wr_en = 1'b1;
            ram_req.wr_addr = idx_ff;
            ram_req.wr_data = {color_ff, ttw_pkg::BLANK_CODE};
            idx_in = idx_ff + ttw_pkg::ADDR_W'(1);
            if (idx_ff == ttw_pkg::LAST_CELL) begin
               state_in = ttw_pkg::ST_RESP;
            end
         end
         ttw_pkg::ST_RESP: begin
            res_valid = 1'b1;
            if (res_ready) begin
               state_in = ttw_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ttw_pkg::ST_IDLE;
         end
      endcase
   end

   assign res.cell_value = value_ff;
   assign res.cursor_row = row_ff;
   assign res.cursor_col = col_ff;
   assign res.did_scroll = scroll_ff;
   assign res.ignored = ignored_ff;

endmodule

>>> sv/text_terminal_writer_top.sv
// response path: put, set and ignored commands go from idle to the response state, a read passes
// through the read wait state, clear through the clear sweep, scroll through the copy and fill sweeps
// a new transaction is taken only after the previous response has entered the output register
// reset: synchronous; a clearing pass writes every cell blank with req_ready low,
// cursor goes home; depends on ttw_pkg, ttw_ctrl, ttw_cell_ram
module text_terminal_writer_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [ttw_pkg::CMD_W-1:0]     req_cmd,
   input  logic [ttw_pkg::CHAR_W-1:0]    req_char_code,
   input  logic [ttw_pkg::COLOR_W-1:0]   req_color,
   input  logic [ttw_pkg::COL_W-1:0]     req_pos_x,
   input  logic [ttw_pkg::ROW_W-1:0]     req_pos_y,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [ttw_pkg::CELL_W-1:0]    rsp_cell_value,
   output logic [ttw_pkg::ROW_W-1:0]     rsp_cursor_row,
   output logic [ttw_pkg::COL_W-1:0]     rsp_cursor_col,
   output logic                          rsp_did_scroll,
   output logic                          rsp_ignored
);

   ttw_pkg::ram_req_type ram_req;
   logic [ttw_pkg::CELL_W-1:0] rd_data;
   logic res_valid;
   logic res_ready;
   ttw_pkg::result_type res;

   logic rsp_valid_ff, rsp_valid_in;
   ttw_pkg::result_type rsp_ff, rsp_in;

   ttw_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_cmd       (req_cmd),
      .req_char_code (req_char_code),
      .req_color     (req_color),
      .req_pos_x     (req_pos_x),
      .req_pos_y     (req_pos_y),
      .ram_req       (ram_req),
      .rd_data       (rd_data),
      .res_valid     (res_valid),
      .res_ready     (res_ready),
      .res           (res)
   );

   ttw_cell_ram u_ram (
      .clock   (clock),
      .ram_req (ram_req),
      .rd_data (rd_data)
   );

   // output register
   assign res_ready = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in = rsp_ff;
      if (res_valid && res_ready) begin
         rsp_valid_in = 1'b1;
         rsp_in = res;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_cell_value = rsp_ff.cell_value;
   assign rsp_cursor_row = rsp_ff.cursor_row;
   assign rsp_cursor_col = rsp_ff.cursor_col;
   assign rsp_did_scroll = rsp_ff.did_scroll;
   assign rsp_ignored = rsp_ff.ignored;

endmodule

>>> sv/ttw_checker.sv
// port-level checks on the text terminal writer response channel
// depends on ttw_pkg; bound to text_terminal_writer_top
module ttw_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [ttw_pkg::CELL_W-1:0]    rsp_cell_value,
   input logic [ttw_pkg::ROW_W-1:0]     rsp_cursor_row,
   input logic [ttw_pkg::COL_W-1:0]     rsp_cursor_col,
   input logic                          rsp_did_scroll,
   input logic                          rsp_ignored
);

   // stalled response transaction holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_cell_value) &&
      $stable(rsp_cursor_row) && $stable(rsp_cursor_col))
      else $error("response changed while stalled");

   // cursor always on screen
   a_cursor_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ({1'b0, rsp_cursor_col} < ttw_pkg::COLUMNS_C) &&
      ({1'b0, rsp_cursor_row} < ttw_pkg::ROWS_C))
      else $error("cursor off screen");

   // scroll leaves cursor at start of last row
   a_scroll_cursor: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_did_scroll |-> rsp_cursor_row == ttw_pkg::ROW_LAST &&
      rsp_cursor_col == '0)
      else $error("scroll with wrong cursor");

   // ignored command returns no data and never scrolls
   a_ignored_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ignored |-> rsp_cell_value == '0 && !rsp_did_scroll)
      else $error("ignored command with data or scroll");

endmodule

bind text_terminal_writer_top ttw_checker u_ttw_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_cell_value (rsp_cell_value),
   .rsp_cursor_row (rsp_cursor_row),
   .rsp_cursor_col (rsp_cursor_col),
   .rsp_did_scroll (rsp_did_scroll),
   .rsp_ignored    (rsp_ignored)
);

>>> tb/testbench.sv
`timescale 1ns / 1ps
// self-checking testbench for text_terminal_writer_top: directed table, then random commands
// keeps its own screen and cursor copy to predict responses the table does not give; depends on ttw_pkg and the rtl
module testbench;
   import ttw_pkg::*;

   localparam int STALL_LIMIT = 40000;
   localparam int RANDOM_CMDS = 500;

   localparam result_type AT_HOME_BLANK = {BLANK_CELL, 5'd0, 7'd0, 1'b0, 1'b0};
   localparam result_type AT_HOME_EMPTY = {16'h0000, 5'd0, 7'd0, 1'b0, 1'b0};
   localparam result_type AT_HOME_SKIPPED = {16'h0000, 5'd0, 7'd0, 1'b0, 1'b1};
   localparam result_type AT_HOME_FULL = {16'hFFFF, 5'd0, 7'd0, 1'b0, 1'b0};

   typedef enum {SINK_OPEN, SINK_COIN, SINK_SLOW} sink_mode_type;

   typedef struct {
      cmd_type op;
      logic [CHAR_W-1:0] ch;
      logic [COLOR_W-1:0] attr;
      logic [COL_W-1:0] x;
      logic [ROW_W-1:0] y;
      int reps;
      bit typed;
      result_type want;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [CMD_W-1:0] req_cmd = '0;
   logic [CHAR_W-1:0] req_char_code = '0;
   logic [COLOR_W-1:0] req_color = '0;
   logic [COL_W-1:0] req_pos_x = '0;
   logic [ROW_W-1:0] req_pos_y = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [CELL_W-1:0] rsp_cell_value;
   logic [ROW_W-1:0] rsp_cursor_row;
   logic [COL_W-1:0] rsp_cursor_col;
   logic rsp_did_scroll;
   logic rsp_ignored;

   logic [CELL_W-1:0] screen_copy [CELL_COUNT];
   int cursor_row;
   int cursor_col;
   result_type screen_rsp_q [$];
   result_type head_rsp;
   int mismatches = 0;
   int cmds_accepted = 0;
   int burst_left = 0;
   int idle_cycles = 0;
   sink_mode_type sink_mode = SINK_OPEN;
   int sink_hold = 0;
   stim_row_type dir_rows [0:20];

   text_terminal_writer_top DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_cmd(req_cmd),
      .req_char_code(req_char_code),
      .req_color(req_color),
      .req_pos_x(req_pos_x),
      .req_pos_y(req_pos_y),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_cell_value(rsp_cell_value),
      .rsp_cursor_row(rsp_cursor_row),
      .rsp_cursor_col(rsp_cursor_col),
      .rsp_did_scroll(rsp_did_scroll),
      .rsp_ignored(rsp_ignored)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic result_type apply_terminal_cmd(input cmd_type op,
                                                     input logic [CHAR_W-1:0] ch,
                                                     input logic [COLOR_W-1:0] attr,
                                                     input logic [COL_W-1:0] x,
                                                     input logic [ROW_W-1:0] y);
      result_type r;
      bit on_grid;
      int idx;
      r = '0;
      on_grid = (int'(x) < COLUMNS) && (int'(y) < ROWS);
      case (op)
         CMD_PUT: begin
            if (ch == NEWLINE_CODE) begin
               cursor_col = 0;
               cursor_row++;
            end else begin
               idx = cursor_row * COLUMNS + cursor_col;
               if (idx < CELL_COUNT) screen_copy[ADDR_W'(idx)] = {attr, ch};
               cursor_col++;
               if (cursor_col >= COLUMNS) begin
                  cursor_col = 0;
                  cursor_row++;
               end
            end
            if (cursor_row >= ROWS) begin
               for (idx = 0; idx + COLUMNS < CELL_COUNT; idx++)
                  screen_copy[ADDR_W'(idx)] = screen_copy[ADDR_W'(idx + COLUMNS)];
               for (idx = (ROWS - 1) * COLUMNS; idx < CELL_COUNT; idx++)
                  screen_copy[ADDR_W'(idx)] = {attr, BLANK_CODE};
               cursor_row = ROWS - 1;
               r.did_scroll = 1'b1;
            end
         end
         CMD_SET: begin
            if (on_grid) screen_copy[ADDR_W'(int'(y) * COLUMNS + int'(x))] = {attr, ch};
            else r.ignored = 1'b1;
         end
         CMD_CLEAR: begin
            for (idx = 0; idx < CELL_COUNT; idx++) screen_copy[ADDR_W'(idx)] = BLANK_CELL;
            cursor_row = 0;
            cursor_col = 0;
         end
         default: begin
            if (on_grid) r.cell_value = screen_copy[ADDR_W'(int'(y) * COLUMNS + int'(x))];
            else r.ignored = 1'b1;
         end
      endcase
      r.cursor_row = ROW_W'(cursor_row);
      r.cursor_col = COL_W'(cursor_col);
      return r;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch on %s: got 0x%0h, expected 0x%0h at %0t", what, got, want, $time);
      mismatches++;
   endtask

   // one transaction; called at a rising edge, returns at the edge that accepts it
   task automatic drive_cmd(input cmd_type op, input logic [CHAR_W-1:0] ch,
                            input logic [COLOR_W-1:0] attr, input logic [COL_W-1:0] x,
                            input logic [ROW_W-1:0] y, input bit typed = 1'b0,
                            input result_type want = '0);
      result_type predicted;
      int gap;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                  : $urandom_range(1, 12);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_cmd <= op;
      req_char_code <= ch;
      req_color <= attr;
      req_pos_x <= x;
      req_pos_y <= y;
      do @(negedge clock); while (!req_ready);
      @(posedge clock);
      predicted = apply_terminal_cmd(op, ch, attr, x, y);
      screen_rsp_q.push_back(typed ? want : predicted);
      cmds_accepted++;
   endtask

   // receiver stall pattern
   always @(posedge clock) begin
      if (sink_hold == 0) begin
         sink_mode <= sink_mode_type'($urandom_range(0, 2));
         sink_hold <= $urandom_range(20, 200);
      end else begin
         sink_hold <= sink_hold - 1;
      end
      case (sink_mode)
         SINK_OPEN: rsp_ready <= 1'b1;
         SINK_COIN: rsp_ready <= 1'($urandom_range(0, 1));
         default: rsp_ready <= ($urandom_range(0, 3) == 0);
      endcase
   end

   always @(negedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (screen_rsp_q.size() == 0) begin
            report_mismatch("unrequested response", int'(rsp_cell_value), 0);
         end else begin
            head_rsp = screen_rsp_q.pop_front();
            if (rsp_cell_value !== head_rsp.cell_value)
               report_mismatch("cell_value", int'(rsp_cell_value),
                               int'(head_rsp.cell_value));
            if (rsp_cursor_row !== head_rsp.cursor_row)
               report_mismatch("cursor_row", int'(rsp_cursor_row),
                               int'(head_rsp.cursor_row));
            if (rsp_cursor_col !== head_rsp.cursor_col)
               report_mismatch("cursor_col", int'(rsp_cursor_col),
                               int'(head_rsp.cursor_col));
            if (rsp_did_scroll !== head_rsp.did_scroll)
               report_mismatch("did_scroll", int'(rsp_did_scroll),
                               int'(head_rsp.did_scroll));
            if (rsp_ignored !== head_rsp.ignored)
               report_mismatch("ignored", int'(rsp_ignored), int'(head_rsp.ignored));
         end
      end
   end

   // watchdog on cycles without any transaction
   always @(negedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int pick;
      int n;
      int k;
      int start_count;
      int row_pick;
      logic [COLOR_W-1:0] run_attr;
      logic [COL_W-1:0] rx;
      logic [ROW_W-1:0] ry;
      logic [CHAR_W-1:0] rc;
      cmd_type op;

      for (k = 0; k < CELL_COUNT; k++) screen_copy[ADDR_W'(k)] = BLANK_CELL;
      cursor_row = 0;
      cursor_col = 0;

      dir_rows = '{
         '{CMD_READ, 8'h00, 8'h00, 7'd0, 5'd0, 1, 1'b1, AT_HOME_BLANK},
         '{CMD_READ, 8'h00, 8'h00, 7'd79, 5'd24, 1, 1'b1, AT_HOME_BLANK},
         '{CMD_READ, 8'h00, 8'h00, 7'd80, 5'd0, 1, 1'b1, AT_HOME_SKIPPED},
         '{CMD_READ, 8'h00, 8'h00, 7'd0, 5'd25, 1, 1'b1, AT_HOME_SKIPPED},
         '{CMD_READ, 8'hFF, 8'hFF, 7'd127, 5'd31, 1, 1'b1, AT_HOME_SKIPPED},
         '{CMD_SET, 8'hFF, 8'hFF, 7'd127, 5'd31, 1, 1'b1, AT_HOME_SKIPPED},
         '{CMD_SET, 8'hFF, 8'hFF, 7'd79, 5'd24, 1, 1'b1, AT_HOME_EMPTY},
         '{CMD_READ, 8'h00, 8'h00, 7'd79, 5'd24, 1, 1'b1, AT_HOME_FULL},
         '{CMD_SET, 8'h00, 8'h00, 7'd0, 5'd0, 1, 1'b1, AT_HOME_EMPTY},
         '{CMD_READ, 8'h00, 8'h00, 7'd0, 5'd0, 1, 1'b1, AT_HOME_EMPTY},
         '{CMD_PUT, 8'h41, 8'h1F, 7'd0, 5'd0, 1, 1'b0, '0},
         '{CMD_PUT, 8'hFF, 8'h80, 7'd127, 5'd31, 1, 1'b0, '0},
         '{CMD_PUT, 8'h00, 8'h01, 7'd0, 5'd0, 1, 1'b0, '0},
         '{CMD_READ, 8'h00, 8'h00, 7'd1, 5'd0, 1, 1'b0, '0},
         '{CMD_PUT, NEWLINE_CODE, 8'h55, 7'd0, 5'd0, 1, 1'b0, '0},
         '{CMD_CLEAR, 8'h00, 8'hAA, 7'd0, 5'd0, 1, 1'b1, AT_HOME_EMPTY},
         '{CMD_READ, 8'h00, 8'h00, 7'd1, 5'd0, 1, 1'b1, AT_HOME_BLANK},
         '{CMD_PUT, NEWLINE_CODE, 8'h00, 7'd0, 5'd0, 24, 1'b0, '0},
         '{CMD_PUT, 8'h5A, 8'h4E, 7'd0, 5'd0, 1, 1'b0, '0},
         '{CMD_PUT, NEWLINE_CODE, 8'hC3, 7'd0, 5'd0, 1, 1'b0, '0},
         '{CMD_READ, 8'h00, 8'h00, 7'd0, 5'd23, 1, 1'b0, '0}
      };

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i])
         repeat (dir_rows[i].reps)
            drive_cmd(dir_rows[i].op, dir_rows[i].ch, dir_rows[i].attr, dir_rows[i].x,
                      dir_rows[i].y, dir_rows[i].typed, dir_rows[i].want);
      drive_cmd(CMD_READ, 8'h00, 8'h00, 7'd0, 5'd24);

      start_count = cmds_accepted;
      while (cmds_accepted - start_count < RANDOM_CMDS) begin
         pick = $urandom_range(0, 99);
         if (pick < 40) begin
            // line of text, wrapping when long
            n = $urandom_range(1, 90);
            run_attr = COLOR_W'($urandom_range(0, 255));
            for (k = 0; k < n; k++) begin
               rc = CHAR_W'($urandom_range(0, 255));
               drive_cmd(CMD_PUT, rc, run_attr, COL_W'($urandom_range(0, 127)),
                         ROW_W'($urandom_range(0, 31)));
            end
            if ($urandom_range(0, 1) == 0)
               drive_cmd(CMD_PUT, NEWLINE_CODE, COLOR_W'($urandom_range(0, 255)), 7'd0, 5'd0);
         end else if (pick < 60) begin
            if ($urandom_range(0, 7) == 0) begin
               rx = COL_W'($urandom_range(0, 127));
               ry = ROW_W'($urandom_range(0, 31));
            end else begin
               rx = COL_W'($urandom_range(0, COLUMNS - 1));
               ry = ROW_W'($urandom_range(0, ROWS - 1));
            end
            drive_cmd(CMD_SET, CHAR_W'($urandom_range(0, 255)),
                      COLOR_W'($urandom_range(0, 255)), rx, ry);
            drive_cmd(CMD_READ, CHAR_W'($urandom_range(0, 255)),
                      COLOR_W'($urandom_range(0, 255)), rx, ry);
         end else if (pick < 80) begin
            // read back around the cursor
            n = $urandom_range(1, 4);
            for (k = 0; k < n; k++) begin
               row_pick = (cursor_row > 0 && $urandom_range(0, 1) == 0) ? cursor_row - 1
                                                                         : cursor_row;
               drive_cmd(CMD_READ, 8'h00, 8'h00, COL_W'($urandom_range(0, COLUMNS - 1)),
                         ROW_W'(row_pick));
            end
         end else if (pick < 95) begin
            op = cmd_type'($urandom_range(0, 3));
            if (op == CMD_CLEAR && $urandom_range(0, 3) != 0) op = CMD_READ;
            drive_cmd(op, CHAR_W'($urandom_range(0, 255)), COLOR_W'($urandom_range(0, 255)),
                      COL_W'($urandom_range(0, 127)), ROW_W'($urandom_range(0, 31)));
         end else begin
            drive_cmd(CMD_CLEAR, CHAR_W'($urandom_range(0, 255)),
                      COLOR_W'($urandom_range(0, 255)),
                      COL_W'($urandom_range(0, 127)), ROW_W'($urandom_range(0, 31)));
         end
      end
      req_valid <= 1'b0;

      while (screen_rsp_q.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (mismatches == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
